// ===== design/periodic_grid_binned_mean_defines.svh =====
// Assertion helpers for the design files; pgbm_back.sv includes them.
`ifndef PERIODIC_GRID_BINNED_MEAN_DEFINES_SVH
`define PERIODIC_GRID_BINNED_MEAN_DEFINES_SVH

`ifndef SYNTH
`define PGBM_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PGBM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PGBM_ASSERT_IMPLIES(label, ante, cons)
`define PGBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/pgbm_pkg.sv =====
package pgbm_pkg;

   localparam int GRID_X_DEF    = 64;
   localparam int GRID_Y_DEF    = 64;
   localparam int MOLECULES_DEF = 16;

   localparam int CELL_W = 10;
   localparam int MOL_W  = 8;
   localparam int ZW     = 34;
   localparam int SUM_W  = 48;
   localparam int CNT_W  = 16;
   localparam int CSR_AW = 5;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_OUTSIDE = 3'd1,
      ST_PERIOD  = 3'd2,
      ST_BAD_MOL = 3'd3,
      ST_READ    = 3'd4,
      ST_EMPTY   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_READ = 2'd1,
      OP_DONE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_LOW_X    = 3'd0,
      REG_LOW_Y    = 3'd1,
      REG_LOW_Z    = 3'd2,
      REG_LENGTH_Z = 3'd3,
      REG_CPU_X    = 3'd4,
      REG_CPU_Y    = 3'd5,
      REG_PERIODIC = 3'd6
   } reg_type;

   typedef struct packed {
      logic signed [31:0] low_x;
      logic signed [31:0] low_y;
      logic signed [31:0] low_z;
      logic [30:0]        length_z;
      logic [31:0]        cpu_x;
      logic [31:0]        cpu_y;
      logic [2:0]         periodic;
   } cfg_type;

   typedef struct packed {
      op_type               op;
      status_type           status;
      logic [CELL_W-1:0]    cx;
      logic [CELL_W-1:0]    cy;
      logic [MOL_W-1:0]     mol;
      logic signed [ZW-1:0] zadd;
   } cmd_type;

endpackage

// ===== design/pgbm_front.sv =====
module pgbm_front #(
   parameter int GRID_X    = pgbm_pkg::GRID_X_DEF,
   parameter int GRID_Y    = pgbm_pkg::GRID_Y_DEF,
   parameter int MOLECULES = pgbm_pkg::MOLECULES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [7:0]        req_molecule_id,
   input  logic [5:0]        req_read_cell_x,
   input  logic [5:0]        req_read_cell_y,
   input  pgbm_pkg::cfg_type cfg,
   output logic              push,
   output pgbm_pkg::cmd_type cmd
);
   import pgbm_pkg::*;

   localparam logic signed [50:0] PER_X = 51'(GRID_X * 65536);
   localparam logic signed [50:0] PER_Y = 51'(GRID_Y * 65536);

   typedef struct packed {
      status_type         code;
      logic signed [50:0] value;
   } fit_type;

   function automatic fit_type fit(input logic signed [50:0] t, input logic signed [50:0] per,
                                   input logic periodic);
      fit_type f;
      logic signed [50:0] w;
      w = t;
      f.code = ST_ADDED;
      if (periodic) begin
         if (t < 0) w = t + per;
         else if (t >= per) w = t - per;
         if (w < 0 || w >= per) f.code = ST_PERIOD;
      end else if (t < 0 || t >= per) begin
         f.code = ST_OUTSIDE;
      end
      f.value = w;
      return f;
   endfunction

   // stage a: offsets from the box corner, split into sign and magnitude
   logic              a_valid_ff, b_valid_ff;
   logic              a_mode_ff, b_mode_ff;
   logic [7:0]        a_mol_ff, b_mol_ff;
   logic [5:0]        a_rcx_ff, a_rcy_ff, b_rcx_ff, b_rcy_ff;
   logic              a_negx_ff, a_negy_ff, b_negx_ff, b_negy_ff;
   logic [32:0]       a_magx_ff, a_magy_ff;
   logic signed [32:0] a_dz_ff, b_dz_ff;
   logic [64:0]       b_px_ff, b_py_ff;

   logic signed [32:0] dx_in, dy_in;
   logic [64:0]       px_in, py_in;

   assign dx_in = {req_pos_x[31], req_pos_x} - {cfg.low_x[31], cfg.low_x};
   assign dy_in = {req_pos_y[31], req_pos_y} - {cfg.low_y[31], cfg.low_y};
   assign px_in = 65'(a_magx_ff) * 65'(cfg.cpu_x);
   assign py_in = 65'(a_magy_ff) * 65'(cfg.cpu_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mode_ff <= req_mode;
         a_mol_ff  <= req_molecule_id;
         a_rcx_ff  <= req_read_cell_x;
         a_rcy_ff  <= req_read_cell_y;
         a_negx_ff <= dx_in[32];
         a_negy_ff <= dy_in[32];
         a_magx_ff <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
         a_magy_ff <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
         a_dz_ff   <= {req_pos_z[31], req_pos_z} - {cfg.low_z[31], cfg.low_z};
      end
      b_mode_ff <= a_mode_ff;
      b_mol_ff  <= a_mol_ff;
      b_rcx_ff  <= a_rcx_ff;
      b_rcy_ff  <= a_rcy_ff;
      b_negx_ff <= a_negx_ff;
      b_negy_ff <= a_negy_ff;
      b_dz_ff   <= a_dz_ff;
      b_px_ff   <= px_in;
      b_py_ff   <= py_in;
   end

   // stage b: floor to Q.16 cell units, wrap, classify
   logic signed [50:0] ux, uy, uz;
   fit_type           fx, fy, fz;
   logic              mol_bad;

   always_comb begin
      ux = b_negx_ff ? -(51'(b_px_ff[64:16]) + 51'(|b_px_ff[15:0])) : 51'(b_px_ff[64:16]);
      uy = b_negy_ff ? -(51'(b_py_ff[64:16]) + 51'(|b_py_ff[15:0])) : 51'(b_py_ff[64:16]);
      uz = 51'(b_dz_ff);
      fx = fit(ux, PER_X, cfg.periodic[0]);
      fy = fit(uy, PER_Y, cfg.periodic[1]);
      fz = fit(uz, 51'(cfg.length_z), cfg.periodic[2]);
      mol_bad = {1'b0, b_mol_ff} >= 9'(MOLECULES);

      cmd.op     = OP_DONE;
      cmd.status = ST_ADDED;
      cmd.cx     = '0;
      cmd.cy     = '0;
      cmd.mol    = b_mol_ff;
      cmd.zadd   = 34'({3'b000, fz.value[30:0]}) + {{2{cfg.low_z[31]}}, cfg.low_z};
      if (!b_mode_ff) begin
         if (fx.code != ST_ADDED) cmd.status = fx.code;
         else if (fy.code != ST_ADDED) cmd.status = fy.code;
         else if (fz.code != ST_ADDED) cmd.status = fz.code;
         else if (mol_bad) cmd.status = ST_BAD_MOL;
         else begin
            cmd.op = OP_ADD;
            cmd.cx = fx.value[16 +: CELL_W];
            cmd.cy = fy.value[16 +: CELL_W];
         end
      end else if (mol_bad) begin
         cmd.status = ST_BAD_MOL;
      end else begin
         cmd.cx = CELL_W'(b_rcx_ff);
         cmd.cy = CELL_W'(b_rcy_ff);
         if (11'(b_rcx_ff) >= 11'(GRID_X) || 11'(b_rcy_ff) >= 11'(GRID_Y))
            cmd.status = ST_EMPTY;
         else
            cmd.op = OP_READ;
      end
   end

   assign push = b_valid_ff;

endmodule

// ===== design/pgbm_queue.sv =====
module pgbm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pgbm_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              head_valid,
   output pgbm_pkg::cmd_type head
);
   import pgbm_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push && fill_ff != 2'd2) begin
         wr_in = ~wr_ff;
         fill_in = fill_in + 2'd1;
      end
      if (pop && fill_ff != 2'd0) begin
         rd_in = ~rd_ff;
         fill_in = fill_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && fill_ff != 2'd2) slot_ff[wr_ff] <= push_data;
   end

   assign head_valid = fill_ff != 2'd0;
   assign head       = slot_ff[rd_ff];

endmodule

// ===== design/pgbm_back.sv =====
`include "periodic_grid_binned_mean_defines.svh"

module pgbm_back #(
   parameter int GRID_X    = pgbm_pkg::GRID_X_DEF,
   parameter int GRID_Y    = pgbm_pkg::GRID_Y_DEF,
   parameter int MOLECULES = pgbm_pkg::MOLECULES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pgbm_pkg::cmd_type q_head,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [5:0]        rsp_bin_x,
   output logic [5:0]        rsp_bin_y,
   output logic signed [31:0] rsp_mean_z,
   output logic [15:0]       rsp_bin_count
);
   import pgbm_pkg::*;

   localparam int NBINS = GRID_X * GRID_Y * MOLECULES;
   localparam int AW    = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam logic [AW-1:0] LAST = AW'(NBINS - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOAD  = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [SUM_W+CNT_W-1:0] mem [NBINS];
   logic [SUM_W+CNT_W-1:0] rd_data_ff, wdata;
   logic                   we;
   logic [AW-1:0]          waddr, raddr;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in, addr_ff, addr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [16:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [5:0]        dcnt_ff, dcnt_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [31:0] rsp_mean_ff, rsp_mean_in;
   logic [15:0]       rsp_cnt_ff, rsp_cnt_in;

   logic [31:0]             idx_full;
   logic signed [SUM_W-1:0] old_sum;
   logic [CNT_W-1:0]        old_cnt;
   logic signed [SUM_W:0]   new_sum;
   logic signed [SUM_W-1:0] sat_sum;
   logic [16:0]             rem_sh;
   logic signed [SUM_W:0]   qs;

   always_comb begin
      idx_full = (32'(q_head.cx) * 32'(GRID_Y) + 32'(q_head.cy)) * 32'(MOLECULES)
                 + 32'(q_head.mol);
      raddr   = idx_full[AW-1:0];
      old_sum = rd_data_ff[SUM_W+CNT_W-1:CNT_W];
      old_cnt = rd_data_ff[CNT_W-1:0];
      new_sum = (SUM_W+1)'(old_sum) + (SUM_W+1)'(cmd_ff.zadd);
      if (new_sum > (SUM_W+1)'(49'sh7FFF_FFFF_FFFF))
         sat_sum = 48'sh7FFF_FFFF_FFFF;
      else if (new_sum < -(SUM_W+1)'(49'sh8000_0000_0000))
         sat_sum = 48'sh8000_0000_0000;
      else
         sat_sum = new_sum[SUM_W-1:0];
      rem_sh = {rem_ff[15:0], quo_ff[SUM_W-1]};
      qs = neg_ff ? -(SUM_W+1)'({1'b0, quo_ff}) : (SUM_W+1)'({1'b0, quo_ff});
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      cmd_in        = cmd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      pop           = 1'b0;
      we            = 1'b0;
      waddr         = addr_ff;
      wdata         = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               cmd_in  = q_head;
               addr_in = raddr;
               if (q_head.op == OP_DONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = q_head.status;
                  rsp_x_in      = q_head.cx[5:0];
                  rsp_y_in      = q_head.cy[5:0];
                  rsp_mean_in   = '0;
                  rsp_cnt_in    = '0;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            we           = 1'b1;
            rsp_x_in     = cmd_ff.cx[5:0];
            rsp_y_in     = cmd_ff.cy[5:0];
            rsp_mean_in  = '0;
            if (cmd_ff.op == OP_ADD) begin
               // a full count freezes the bin
               if (old_cnt != '1) wdata = {sat_sum, old_cnt + CNT_W'(1)};
               else wdata = rd_data_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ADDED;
               rsp_cnt_in    = (old_cnt != '1) ? old_cnt + CNT_W'(1) : old_cnt;
               state_in      = S_IDLE;
            end else if (old_cnt == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_EMPTY;
               rsp_cnt_in    = '0;
               state_in      = S_IDLE;
            end else begin
               neg_in   = old_sum[SUM_W-1];
               quo_in   = old_sum[SUM_W-1] ? SUM_W'(-old_sum) : SUM_W'(old_sum);
               rem_in   = '0;
               dcnt_in  = '0;
               cnt_in   = old_cnt;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, cnt_ff}) begin
               rem_in = rem_sh - {1'b0, cnt_ff};
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'(SUM_W - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_READ;
            rsp_cnt_in    = cnt_ff;
            if (qs > 49'sh0_7FFF_FFFF) rsp_mean_in = 32'sh7FFF_FFFF;
            else if (qs < -49'sh0_8000_0000) rsp_mean_in = 32'sh8000_0000;
            else rsp_mean_in = qs[31:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      cmd_ff        <= cmd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign clearing      = state_ff == S_CLEAR;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bin_x     = rsp_x_ff;
   assign rsp_bin_y     = rsp_y_ff;
   assign rsp_mean_z    = rsp_mean_ff;
   assign rsp_bin_count = rsp_cnt_ff;

   `PGBM_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff)
   `PGBM_ASSERT_IMPLIES(a_no_work_in_clear, state_ff == S_CLEAR, !q_valid)
   `PGBM_ASSERT_IMPLIES(a_divisor_nonzero, state_ff == S_DIV, cnt_ff != '0)

endmodule

// ===== design/periodic_grid_binned_mean.sv =====
// channel   ports                         handshake
// request   start, busy, req_*            transfer when start && !busy
// response  rsp_valid, rsp_*              one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr  APB write, pready tied high
//
// Drop, bad-molecule and off-grid results pass the front stages, queue and idle state;
// an add or an empty bin read adds the load state; a filled bin read, the 48-step divider.
// busy stays high from a transfer through its result strobe; the next transfer can
// come in the cycle after the strobe.
// After reset all GRID_X*GRID_Y*MOLECULES bin entries (65536 by default) are zeroed one
// entry a cycle, with busy high; config writes are taken meanwhile.
module periodic_grid_binned_mean #(
   parameter int GRID_X    = pgbm_pkg::GRID_X_DEF,
   parameter int GRID_Y    = pgbm_pkg::GRID_Y_DEF,
   parameter int MOLECULES = pgbm_pkg::MOLECULES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic signed [31:0]          req_pos_x,
   input  logic signed [31:0]          req_pos_y,
   input  logic signed [31:0]          req_pos_z,
   input  logic [7:0]                  req_molecule_id,
   input  logic [5:0]                  req_read_cell_x,
   input  logic [5:0]                  req_read_cell_y,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [5:0]                  rsp_bin_x,
   output logic [5:0]                  rsp_bin_y,
   output logic signed [31:0]          rsp_mean_z,
   output logic [15:0]                 rsp_bin_count,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pgbm_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import pgbm_pkg::*;

   cfg_type cfg_ff;
   logic    busy_ff, busy_in;
   logic    accept, clearing, push, pop, q_valid, csr_wr;
   cmd_type cmd, q_head;

   assign accept = start && !busy;
   assign busy   = busy_ff || clearing;
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (rsp_valid) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         cfg_ff.low_x    <= '0;
         cfg_ff.low_y    <= '0;
         cfg_ff.low_z    <= '0;
         cfg_ff.length_z <= 31'd65536;
         cfg_ff.cpu_x    <= 32'd65536;
         cfg_ff.cpu_y    <= 32'd65536;
         cfg_ff.periodic <= 3'd7;
      end else begin
         busy_ff <= busy_in;
         if (csr_wr) begin
            unique case (reg_type'(paddr[4:2]))
               REG_LOW_X:    cfg_ff.low_x    <= pwdata;
               REG_LOW_Y:    cfg_ff.low_y    <= pwdata;
               REG_LOW_Z:    cfg_ff.low_z    <= pwdata;
               REG_LENGTH_Z: cfg_ff.length_z <= pwdata[30:0];
               REG_CPU_X:    cfg_ff.cpu_x    <= pwdata;
               REG_CPU_Y:    cfg_ff.cpu_y    <= pwdata;
               REG_PERIODIC: cfg_ff.periodic <= pwdata[2:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (reg_type'(paddr[4:2]))
         REG_LOW_X:    prdata = cfg_ff.low_x;
         REG_LOW_Y:    prdata = cfg_ff.low_y;
         REG_LOW_Z:    prdata = cfg_ff.low_z;
         REG_LENGTH_Z: prdata = {1'b0, cfg_ff.length_z};
         REG_CPU_X:    prdata = cfg_ff.cpu_x;
         REG_CPU_Y:    prdata = cfg_ff.cpu_y;
         REG_PERIODIC: prdata = {29'd0, cfg_ff.periodic};
         default:      prdata = '0;
      endcase
   end

   pgbm_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .MOLECULES(MOLECULES)) u_front (
      .clock, .reset, .accept,
      .req_mode, .req_pos_x, .req_pos_y, .req_pos_z,
      .req_molecule_id, .req_read_cell_x, .req_read_cell_y,
      .cfg(cfg_ff), .push, .cmd
   );

   pgbm_queue u_queue (
      .clock, .reset, .push, .push_data(cmd), .pop,
      .head_valid(q_valid), .head(q_head)
   );

   pgbm_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .MOLECULES(MOLECULES)) u_back (
      .clock, .reset, .q_valid, .q_head, .pop, .clearing,
      .rsp_valid, .rsp_status, .rsp_bin_x, .rsp_bin_y, .rsp_mean_z, .rsp_bin_count
   );

endmodule
